### rtl/core/r2y420_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r2y420_pkg
// Shared constants for the RGBA to YUV 4:2:0 converter: register map,
// field widths, reset values and BT.601 integer weights.
// ----------------------------------------------------------------------------
package r2y420_pkg;

   // Register map: index = byte address / 4
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [2:0] reg_index_type;

   localparam reg_index_type REG_FRAME_WIDTH   = 3'd0;
   localparam reg_index_type REG_FRAME_HEIGHT  = 3'd1;
   localparam reg_index_type REG_LUMA_STRIDE   = 3'd2;
   localparam reg_index_type REG_CHROMA_STRIDE = 3'd3;
   localparam reg_index_type REG_CHROMA_PITCH  = 3'd4;
   localparam reg_index_type REG_LUMA_BASE     = 3'd5;
   localparam reg_index_type REG_CB_BASE       = 3'd6;
   localparam reg_index_type REG_CR_BASE       = 3'd7;

   // Register field widths
   localparam int unsigned DIM_REG_W    = 13;
   localparam int unsigned STRIDE_REG_W = 16;
   localparam int unsigned STEP_REG_W   = 3;
   localparam int unsigned BASE_REG_W   = 32;

   // Register reset values
   localparam logic [DIM_REG_W-1:0]    RST_FRAME_WIDTH   = 13'd640;
   localparam logic [DIM_REG_W-1:0]    RST_FRAME_HEIGHT  = 13'd480;
   localparam logic [STRIDE_REG_W-1:0] RST_LUMA_STRIDE   = 16'd640;
   localparam logic [STRIDE_REG_W-1:0] RST_CHROMA_STRIDE = 16'd640;
   localparam logic [STEP_REG_W-1:0]   RST_CHROMA_PITCH  = 3'd2;
   localparam logic [BASE_REG_W-1:0]   RST_BASE          = 32'd0;

   // Pixel and output widths
   localparam int unsigned PIX_W      = 8;
   localparam int unsigned OUT_ADDR_W = 32;
   localparam int unsigned SUM_W      = 17;

   typedef logic [PIX_W-1:0] pixel_type;

   // BT.601 integer weights (magnitudes; signs are applied in the sums)
   localparam logic [SUM_W-1:0] Y_R_WT   = 17'd77;
   localparam logic [SUM_W-1:0] Y_G_WT   = 17'd150;
   localparam logic [SUM_W-1:0] Y_B_WT   = 17'd29;
   localparam logic [SUM_W-1:0] CB_R_WT  = 17'd43;
   localparam logic [SUM_W-1:0] CB_G_WT  = 17'd85;
   localparam logic [SUM_W-1:0] CB_B_WT  = 17'd128;
   localparam logic [SUM_W-1:0] CR_R_WT  = 17'd128;
   localparam logic [SUM_W-1:0] CR_G_WT  = 17'd107;
   localparam logic [SUM_W-1:0] CR_B_WT  = 17'd21;
   // 128 << 8: adds the chroma offset of 128 to the shifted result
   localparam logic [SUM_W-1:0] CHROMA_BIAS = 17'd32768;

endpackage : r2y420_pkg
`default_nettype wire

### rtl/core/rgba_to_yuv420_converter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_to_yuv420_converter_unit
// Converts a raster stream of RGBA pixels into BT.601 luma for every pixel
// and Cb/Cr for every even row and even column, with plane write addresses.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-------------------------------
//   req     | in        | req_valid / req_stall  | red, green, blue, alpha
//   rsp     | out       | rsp_valid / rsp_stall  | luma, addresses, chroma, flags
//   csr     | in/out    | APB psel/penable/pready| 8 x 32-bit registers
//
// Throughput: one request per clock while rsp_stall is low; each result passes
//   through the input stage, then the output register.
// The raster counters and address offsets advance when a request is accepted,
//   so the next pixel's position is ready in the following cycle.
// Reset (synchronous) clears counters, offsets and valid flags and restores
//   the register defaults.
// rsp_stall holds the output register; the input stage still takes a request
//   while it is empty, so req_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module rgba_to_yuv420_converter_unit
   import r2y420_pkg::*;
#(
   parameter int unsigned ADDRESS_BITS  = 32,
   parameter int unsigned MAX_DIMENSION = 4096
) (
   input  wire logic                    clock,
   input  wire logic                    reset,

   // Pixel requests
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire pixel_type               req_red,
   input  wire pixel_type               req_green,
   input  wire pixel_type               req_blue,
   input  wire pixel_type               req_alpha,

   // Converted results
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      pixel_type               rsp_luma,
   output      logic [OUT_ADDR_W-1:0]   rsp_luma_address,
   output      logic                    rsp_chroma_valid,
   output      pixel_type               rsp_cb_value,
   output      pixel_type               rsp_cr_value,
   output      logic [OUT_ADDR_W-1:0]   rsp_cb_address,
   output      logic [OUT_ADDR_W-1:0]   rsp_cr_address,
   output      logic                    rsp_row_last,
   output      logic                    rsp_frame_last,

   // Register port
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [CSR_DATA_W-1:0]   csr_prdata,
   output      logic                    csr_pready
);

   // Counter holds 0 .. MAX_DIMENSION-1; compare width also holds the
   // 13-bit register and MAX_DIMENSION itself.
   localparam int unsigned CNT_W = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
   localparam int unsigned CMP_W = (CNT_W + 1 > DIM_REG_W) ? CNT_W + 1 : DIM_REG_W;
   localparam int unsigned AB    = ADDRESS_BITS;
   // Common width for moving between address space and 32-bit fields
   localparam int unsigned EXT_W = (AB > OUT_ADDR_W) ? AB : OUT_ADDR_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [DIM_REG_W-1:0]    frame_width_ff, frame_height_ff;
   logic [STRIDE_REG_W-1:0] luma_stride_ff, chroma_stride_ff;
   logic [STEP_REG_W-1:0]   chroma_pitch_ff;
   logic [BASE_REG_W-1:0]   luma_base_ff, cb_base_ff, cr_base_ff;

   logic          csr_write;
   reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= RST_FRAME_WIDTH;
         frame_height_ff  <= RST_FRAME_HEIGHT;
         luma_stride_ff   <= RST_LUMA_STRIDE;
         chroma_stride_ff <= RST_CHROMA_STRIDE;
         chroma_pitch_ff  <= RST_CHROMA_PITCH;
         luma_base_ff     <= RST_BASE;
         cb_base_ff       <= RST_BASE;
         cr_base_ff       <= RST_BASE;
      end else if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH:   frame_width_ff   <= csr_pwdata[DIM_REG_W-1:0];
            REG_FRAME_HEIGHT:  frame_height_ff  <= csr_pwdata[DIM_REG_W-1:0];
            REG_LUMA_STRIDE:   luma_stride_ff   <= csr_pwdata[STRIDE_REG_W-1:0];
            REG_CHROMA_STRIDE: chroma_stride_ff <= csr_pwdata[STRIDE_REG_W-1:0];
            REG_CHROMA_PITCH:  chroma_pitch_ff  <= csr_pwdata[STEP_REG_W-1:0];
            REG_LUMA_BASE:     luma_base_ff     <= csr_pwdata[BASE_REG_W-1:0];
            REG_CB_BASE:       cb_base_ff       <= csr_pwdata[BASE_REG_W-1:0];
            REG_CR_BASE:       cr_base_ff       <= csr_pwdata[BASE_REG_W-1:0];
            default:           ;
         endcase
      end
   end

   // Read back: zero-extend each register to the bus
   always_comb begin
      case (csr_index)
         REG_FRAME_WIDTH:   csr_prdata = CSR_DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT:  csr_prdata = CSR_DATA_W'(frame_height_ff);
         REG_LUMA_STRIDE:   csr_prdata = CSR_DATA_W'(luma_stride_ff);
         REG_CHROMA_STRIDE: csr_prdata = CSR_DATA_W'(chroma_stride_ff);
         REG_CHROMA_PITCH:  csr_prdata = CSR_DATA_W'(chroma_pitch_ff);
         REG_LUMA_BASE:     csr_prdata = CSR_DATA_W'(luma_base_ff);
         REG_CB_BASE:       csr_prdata = CSR_DATA_W'(cb_base_ff);
         REG_CR_BASE:       csr_prdata = CSR_DATA_W'(cr_base_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline handshake
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff;
   logic s1_load, s2_load;

   // Advance into the output register whenever it is empty or being drained
   assign s2_load   = s1_valid_ff & (~s2_valid_ff | ~rsp_stall);
   // Hold off requests only while the input stage is full and cannot move
   assign req_stall = s1_valid_ff & ~s2_load;
   assign s1_load   = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (s2_load) begin
            s2_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Raster position and address offsets (advance on each accepted request)
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0] col_cnt_ff, col_cnt_in;
   logic [CNT_W-1:0] row_cnt_ff, row_cnt_in;
   logic [AB-1:0]    luma_row_off_ff, luma_row_off_in;
   logic [AB-1:0]    chroma_row_off_ff, chroma_row_off_in;
   logic [AB-1:0]    chroma_col_off_ff, chroma_col_off_in;

   logic [CMP_W-1:0] width_raw, height_raw, width_eff, height_eff;
   logic             even_row, chroma_hit, row_last, frame_last;

   // Clamp the dimensions: zero counts as one, saturate at MAX_DIMENSION
   always_comb begin
      width_raw  = CMP_W'(frame_width_ff);
      height_raw = CMP_W'(frame_height_ff);
      if (width_raw == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_raw > CMP_W'(MAX_DIMENSION)) begin
         width_eff = CMP_W'(MAX_DIMENSION);
      end else begin
         width_eff = width_raw;
      end
      if (height_raw == '0) begin
         height_eff = CMP_W'(1);
      end else if (height_raw > CMP_W'(MAX_DIMENSION)) begin
         height_eff = CMP_W'(MAX_DIMENSION);
      end else begin
         height_eff = height_raw;
      end
   end

   // A counter at or past the edge (after a mid-frame resize) ends its row
   assign even_row   = ~row_cnt_ff[0];
   assign chroma_hit = even_row & ~col_cnt_ff[0];
   assign row_last   = (CMP_W'(col_cnt_ff) + CMP_W'(1)) >= width_eff;
   assign frame_last = row_last & ((CMP_W'(row_cnt_ff) + CMP_W'(1)) >= height_eff);

   always_comb begin
      col_cnt_in        = col_cnt_ff;
      row_cnt_in        = row_cnt_ff;
      luma_row_off_in   = luma_row_off_ff;
      chroma_row_off_in = chroma_row_off_ff;
      chroma_col_off_in = chroma_col_off_ff;
      if (s1_load) begin
         if (frame_last) begin
            // Wrap everything back to the top-left pixel
            col_cnt_in        = '0;
            row_cnt_in        = '0;
            luma_row_off_in   = '0;
            chroma_row_off_in = '0;
            chroma_col_off_in = '0;
         end else if (row_last) begin
            col_cnt_in      = '0;
            row_cnt_in      = row_cnt_ff + CNT_W'(1);
            luma_row_off_in = luma_row_off_ff + AB'(luma_stride_ff);
            // Chroma rows advance only after rows that carried chroma
            if (even_row) begin
               chroma_row_off_in = chroma_row_off_ff + AB'(chroma_stride_ff);
            end
            chroma_col_off_in = '0;
         end else begin
            col_cnt_in = col_cnt_ff + CNT_W'(1);
            if (chroma_hit) begin
               chroma_col_off_in = chroma_col_off_ff + AB'(chroma_pitch_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff        <= '0;
         row_cnt_ff        <= '0;
         luma_row_off_ff   <= '0;
         chroma_row_off_ff <= '0;
         chroma_col_off_ff <= '0;
      end else begin
         col_cnt_ff        <= col_cnt_in;
         row_cnt_ff        <= row_cnt_in;
         luma_row_off_ff   <= luma_row_off_in;
         chroma_row_off_ff <= chroma_row_off_in;
         chroma_col_off_ff <= chroma_col_off_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input stage: capture the pixel with its position sums and flags.
   // Alpha is not needed by any output and is dropped here.
   // ---------------------------------------------------------------------
   pixel_type     s1_red_ff, s1_green_ff, s1_blue_ff;
   logic [AB-1:0] s1_luma_off_ff, s1_chroma_off_ff;
   logic          s1_chroma_ff, s1_row_last_ff, s1_frame_last_ff;

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_red_ff        <= req_red;
         s1_green_ff      <= req_green;
         s1_blue_ff       <= req_blue;
         s1_luma_off_ff   <= luma_row_off_ff + AB'(col_cnt_ff);
         s1_chroma_off_ff <= chroma_row_off_ff + chroma_col_off_ff;
         s1_chroma_ff     <= chroma_hit;
         s1_row_last_ff   <= row_last;
         s1_frame_last_ff <= frame_last;
      end
   end

   // ---------------------------------------------------------------------
   // Color math and final addresses, then the output register
   // ---------------------------------------------------------------------
   logic [SUM_W-1:0] red_ext, green_ext, blue_ext;
   logic [SUM_W-1:0] y_sum, cb_sum, cr_sum;
   logic [EXT_W-1:0] luma_base_ext, cb_base_ext, cr_base_ext;
   logic [AB-1:0]    luma_addr_ab, cb_addr_ab, cr_addr_ab;
   logic [EXT_W-1:0] luma_addr_ext, cb_addr_ext, cr_addr_ext;

   assign red_ext   = SUM_W'(s1_red_ff);
   assign green_ext = SUM_W'(s1_green_ff);
   assign blue_ext  = SUM_W'(s1_blue_ff);

   // Chroma sums stay within 0..65535 after the bias, so modular
   // arithmetic in SUM_W bits gives the exact floor-shifted value.
   assign y_sum  = Y_R_WT * red_ext + Y_G_WT * green_ext + Y_B_WT * blue_ext;
   assign cb_sum = CHROMA_BIAS + CB_B_WT * blue_ext
                 - CB_R_WT * red_ext - CB_G_WT * green_ext;
   assign cr_sum = CHROMA_BIAS + CR_R_WT * red_ext
                 - CR_G_WT * green_ext - CR_B_WT * blue_ext;

   // Bases wrap into the address space; results map back to 32-bit fields
   assign luma_base_ext = EXT_W'(luma_base_ff);
   assign cb_base_ext   = EXT_W'(cb_base_ff);
   assign cr_base_ext   = EXT_W'(cr_base_ff);
   assign luma_addr_ab  = luma_base_ext[AB-1:0] + s1_luma_off_ff;
   assign cb_addr_ab    = cb_base_ext[AB-1:0] + s1_chroma_off_ff;
   assign cr_addr_ab    = cr_base_ext[AB-1:0] + s1_chroma_off_ff;
   assign luma_addr_ext = EXT_W'(luma_addr_ab);
   assign cb_addr_ext   = EXT_W'(cb_addr_ab);
   assign cr_addr_ext   = EXT_W'(cr_addr_ab);

   always_ff @(posedge clock) begin
      if (s2_load) begin
         rsp_luma         <= y_sum[15:8];
         rsp_luma_address <= luma_addr_ext[OUT_ADDR_W-1:0];
         rsp_chroma_valid <= s1_chroma_ff;
         rsp_row_last     <= s1_row_last_ff;
         rsp_frame_last   <= s1_frame_last_ff;
         // Pixels without chroma report zero chroma values and addresses
         if (s1_chroma_ff) begin
            rsp_cb_value   <= cb_sum[15:8];
            rsp_cr_value   <= cr_sum[15:8];
            rsp_cb_address <= cb_addr_ext[OUT_ADDR_W-1:0];
            rsp_cr_address <= cr_addr_ext[OUT_ADDR_W-1:0];
         end else begin
            rsp_cb_value   <= '0;
            rsp_cr_value   <= '0;
            rsp_cb_address <= '0;
            rsp_cr_address <= '0;
         end
      end
   end

   assign rsp_valid = s2_valid_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // The last pixel of a frame also closes its row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> rsp_row_last)
      else $error("frame_last without row_last");

   // Results without chroma carry zero chroma fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_chroma_valid |->
         rsp_cb_value == '0 && rsp_cr_value == '0 &&
         rsp_cb_address == '0 && rsp_cr_address == '0)
      else $error("chroma fields set on a pixel without chroma");

   // Column offset restarts with the column counter
   assert property (@(posedge clock) disable iff (reset)
      col_cnt_ff == '0 |-> chroma_col_off_ff == '0)
      else $error("chroma column offset not cleared at row start");

   // Odd rows never advance the chroma column offset
   assert property (@(posedge clock) disable iff (reset)
      row_cnt_ff[0] |-> chroma_col_off_ff == '0)
      else $error("chroma column offset moved on an odd row");

endmodule : rgba_to_yuv420_converter_unit
`default_nettype wire
